### sv/lpr_pkg.sv
`default_nettype none
package lpr_pkg;

   localparam int CFG_W = 5;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
   localparam int FAULT_W = 16;
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   localparam logic CMD_REFERENCE = 1'b0;
   localparam logic CMD_RESTART   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic cap_en;
      logic look_en;
      logic upd_en;
   } ctrl_type;

endpackage
`default_nettype wire

### sv/lpr_if.sv
`default_nettype none
interface lpr_req_if #(
   parameter int PAGE_BITS = 8
);
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output command, output page_number, input ready);
   modport sink   (input valid, input command, input page_number, output ready);
endinterface

interface lpr_rsp_if #(
   parameter int IDX_W     = 4,
   parameter int PAGE_BITS = 8
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [IDX_W-1:0]              frame_index;
   logic                          evicted_valid;
   logic [PAGE_BITS-1:0]          evicted_page;
   logic [lpr_pkg::FAULT_W-1:0]   fault_count;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_count, output ready);
endinterface
`default_nettype wire

### sv/lpr_ctrl.sv
`default_nettype none
module lpr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpr_pkg::ctrl_type ctrl
);

   lpr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl      = '0;
      unique case (state_ff)
         lpr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.cap_en = 1'b1;
               state_in    = lpr_pkg::S_LOOKUP;
            end
         end
         lpr_pkg::S_LOOKUP: begin
            ctrl.look_en = 1'b1;
            state_in     = lpr_pkg::S_UPDATE;
         end
         lpr_pkg::S_UPDATE: begin
            // commit only once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.upd_en = 1'b1;
               state_in    = lpr_pkg::S_IDLE;
            end
         end
         default: state_in = lpr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      if (ctrl.upd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/lpr_datapath.sv
`default_nettype none
module lpr_datapath #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lpr_pkg::ctrl_type               ctrl,
   input  logic                            csr_write_enable,
   input  logic [lpr_pkg::CFG_W-1:0]       csr_write_data,
   input  logic                            req_command,
   input  logic [PAGE_BITS-1:0]            req_page_number,
   output logic                            rsp_hit,
   output logic [$clog2(MAX_FRAMES)-1:0]   rsp_frame_index,
   output logic                            rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]            rsp_evicted_page,
   output logic [lpr_pkg::FAULT_W-1:0]     rsp_fault_count
);

   localparam int IDX_W  = $clog2(MAX_FRAMES);
   localparam int RANK_W = IDX_W;
   localparam int FILL_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W  = (FILL_W > lpr_pkg::CFG_W) ? FILL_W : lpr_pkg::CFG_W;

   logic [lpr_pkg::CFG_W-1:0]   cfg_ff;
   logic                        cmd_ff;
   logic [PAGE_BITS-1:0]        page_ff;
   logic [PAGE_BITS-1:0]        frame_page_ff [MAX_FRAMES];
   logic [RANK_W-1:0]           rank_ff [MAX_FRAMES];
   logic [FILL_W-1:0]           filled_ff;
   logic [lpr_pkg::FAULT_W-1:0] faults_ff, faults_in;

   logic                        hit_ff, fill_ff;
   logic [IDX_W-1:0]            sel_ff;
   logic [RANK_W-1:0]           sel_rank_ff;
   logic [PAGE_BITS-1:0]        evpage_ff;

   logic                        out_hit_ff, out_evv_ff;
   logic [IDX_W-1:0]            out_idx_ff;
   logic [PAGE_BITS-1:0]        out_evpage_ff;
   logic [lpr_pkg::FAULT_W-1:0] out_faults_ff;

   logic [MAX_FRAMES-1:0] valid_vec, match_vec, evict_vec, zero_vec;
   logic [CMP_W-1:0]      cfg_ext, usable;
   logic [RANK_W-1:0]     last_rank, match_rank;
   logic [FILL_W-1:0]     filled_m1;
   logic [IDX_W-1:0]      match_idx, evict_idx, sel_c;
   logic [PAGE_BITS-1:0]  evict_page;
   logic                  hit_c, fill_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lpr_pkg::CFG_RESET;
      end else if (csr_write_enable) begin
         cfg_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap_en) begin
         cmd_ff  <= req_command;
         page_ff <= req_page_number;
      end
   end

   // associative compare and lru search over the filled frames
   assign filled_m1 = filled_ff - FILL_W'(1);
   assign last_rank = filled_m1[RANK_W-1:0];

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         valid_vec[i] = FILL_W'(i) < filled_ff;
         match_vec[i] = valid_vec[i] && (frame_page_ff[i] == page_ff);
         evict_vec[i] = valid_vec[i] && (rank_ff[i] == last_rank);
         zero_vec[i]  = valid_vec[i] && (rank_ff[i] == '0);
      end
   end

   always_comb begin
      match_idx  = '0;
      match_rank = '0;
      evict_idx  = '0;
      evict_page = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (match_vec[i]) begin
            match_idx  = match_idx | IDX_W'(i);
            match_rank = match_rank | rank_ff[i];
         end
         if (evict_vec[i]) begin
            evict_idx  = evict_idx | IDX_W'(i);
            evict_page = evict_page | frame_page_ff[i];
         end
      end
   end

   // out-of-range limit values clamp to one and to the frame count
   assign cfg_ext = CMP_W'(cfg_ff);
   always_comb begin
      if (cfg_ff == '0) begin
         usable = CMP_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
         usable = CMP_W'(MAX_FRAMES);
      end else begin
         usable = cfg_ext;
      end
   end

   assign hit_c  = |match_vec;
   assign fill_c = !hit_c && (CMP_W'(filled_ff) < usable);

   always_comb begin
      if (hit_c) begin
         sel_c = match_idx;
      end else if (fill_c) begin
         sel_c = filled_ff[IDX_W-1:0];
      end else begin
         sel_c = evict_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.look_en) begin
         hit_ff      <= hit_c;
         fill_ff     <= fill_c;
         sel_ff      <= sel_c;
         sel_rank_ff <= match_rank;
         evpage_ff   <= evict_page;
      end
   end

   always_comb begin
      if (cmd_ff == lpr_pkg::CMD_RESTART) begin
         faults_in = '0;
      end else if (!hit_ff && (faults_ff != lpr_pkg::FAULT_MAX)) begin
         faults_in = faults_ff + lpr_pkg::FAULT_W'(1);
      end else begin
         faults_in = faults_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         faults_ff <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (ctrl.upd_en) begin
         faults_ff <= faults_in;
         if (cmd_ff == lpr_pkg::CMD_RESTART) begin
            filled_ff <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
               rank_ff[i] <= '0;
            end
         end else begin
            if (fill_ff) begin
               filled_ff <= filled_ff + FILL_W'(1);
            end
            // a miss ages every other frame, a hit only the more recent ones
            for (int i = 0; i < MAX_FRAMES; i++) begin
               if (IDX_W'(i) == sel_ff) begin
                  rank_ff[i] <= '0;
               end else if (valid_vec[i] && (!hit_ff || (rank_ff[i] < sel_rank_ff))) begin
                  rank_ff[i] <= rank_ff[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en && (cmd_ff != lpr_pkg::CMD_RESTART) && !hit_ff) begin
         frame_page_ff[sel_ff] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en) begin
         out_faults_ff <= faults_in;
         if (cmd_ff == lpr_pkg::CMD_RESTART) begin
            out_hit_ff    <= 1'b0;
            out_idx_ff    <= '0;
            out_evv_ff    <= 1'b0;
            out_evpage_ff <= '0;
         end else begin
            out_hit_ff    <= hit_ff;
            out_idx_ff    <= sel_ff;
            out_evv_ff    <= !hit_ff && !fill_ff;
            out_evpage_ff <= (!hit_ff && !fill_ff) ? evpage_ff : '0;
         end
      end
   end

   assign rsp_hit           = out_hit_ff;
   assign rsp_frame_index   = out_idx_ff;
   assign rsp_evicted_valid = out_evv_ff;
   assign rsp_evicted_page  = out_evpage_ff;
   assign rsp_fault_count   = out_faults_ff;

`ifndef ASSERT_OFF
   a_one_mru: assert property (@(posedge clock) disable iff (reset)
      (filled_ff != '0) |-> $onehot(zero_vec))
      else $error("filled frames do not hold exactly one most recent rank");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page resident in more than one frame");

   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd_en |-> !(hit_ff && fill_ff))
      else $error("reference marked both hit and fill");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(MAX_FRAMES))
      else $error("fill count beyond frame count");

   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.upd_en && (cmd_ff != lpr_pkg::CMD_RESTART)) |=> faults_ff >= $past(faults_ff))
      else $error("fault count decreased without restart");
`endif

endmodule
`default_nettype wire

### sv/lru_page_replacement.sv
// lru page replacement over a fully associative set of frames
//
// req_bus carries one item per transfer: command (reference or restart) and
// page_number. rsp_bus returns exactly one result per item: hit, frame_index,
// evicted_valid, evicted_page and the saturating fault_count.
// csr_write_enable/csr_write_data write frames_in_use (0 acts as 1, values
// above MAX_FRAMES act as MAX_FRAMES); write it only while the block is idle.
//
// each item passes capture, parallel tag compare and lru search across all
// frames, then the rank/page update that loads the output register. the
// result becomes valid when that update loads the output register, and a new
// item is taken only after the controller's capture-lookup-update sequence
// has returned to idle, not while the previous item is still in flight.
// the output register parts the two sides: the next item is accepted while a
// result still waits. if the receiver stalls, the following item waits in its
// update step, and req_bus stays not ready until that result can be loaded.
// reset sets frames_in_use to 16 (clamped), clears the fill count, the
// recency ranks and the fault count; page tags are not cleared.
`default_nettype none
module lru_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   lpr_req_if.sink                   req_bus,
   lpr_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [lpr_pkg::CFG_W-1:0] csr_write_data
);

   lpr_pkg::ctrl_type ctrl;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   lpr_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_command       (req_bus.command),
      .req_page_number   (req_bus.page_number),
      .rsp_hit           (rsp_bus.hit),
      .rsp_frame_index   (rsp_bus.frame_index),
      .rsp_evicted_valid (rsp_bus.evicted_valid),
      .rsp_evicted_page  (rsp_bus.evicted_page),
      .rsp_fault_count   (rsp_bus.fault_count)
   );

endmodule
`default_nettype wire

### dv/tb_lru_page_replacement.sv
module tb_lru_page_replacement;

   localparam int NFRAMES = 16;
   localparam int LIMIT_CYCLES = 150000;
   localparam int THRASH_REFS = 16;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 145;

   localparam logic C_REF = lpr_pkg::CMD_REFERENCE;
   localparam logic C_RST = lpr_pkg::CMD_RESTART;

   typedef struct packed {
      logic        hit;
      logic [3:0]  frame_index;
      logic        evicted_valid;
      logic [7:0]  evicted_page;
      logic [15:0] fault_count;
   } lru_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic           cmd;
      logic [7:0]     page;
      logic [4:0]     csr;
      logic           typed;
      lru_result_type want;
   } lru_row_type;

   localparam int DIR_N = 26;
   // typed rows carry the result that is obvious by hand, the rest use the predictor
   localparam lru_row_type DIR_ROWS [DIR_N] = '{
      '{ROW_ITEM, C_REF, 8'h00, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd1}},
      '{ROW_ITEM, C_REF, 8'hff, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 8'h00, 16'd2}},
      '{ROW_ITEM, C_REF, 8'h00, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 8'h00, 16'd2}},
      '{ROW_ITEM, C_REF, 8'hff, 5'd0,  1'b1, '{1'b1, 4'd1, 1'b0, 8'h00, 16'd2}},
      '{ROW_ITEM, C_RST, 8'hff, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd0}},
      '{ROW_ITEM, C_REF, 8'haa, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd1}},
      '{ROW_ITEM, C_REF, 8'h55, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 8'h00, 16'd2}},
      '{ROW_ITEM, C_REF, 8'h01, 5'd0,  1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h02, 5'd0,  1'b0, '0},
      // limit dropped below the fill level: filled frames must still hit
      '{ROW_CSR,  C_REF, 8'h00, 5'd0,  1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h55, 5'd0,  1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h03, 5'd0,  1'b0, '0},
      '{ROW_ITEM, C_RST, 8'h00, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd0}},
      '{ROW_ITEM, C_REF, 8'h12, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd1}},
      '{ROW_ITEM, C_REF, 8'h34, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 8'h12, 16'd2}},
      '{ROW_CSR,  C_REF, 8'h00, 5'd31, 1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h34, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 8'h00, 16'd2}},
      '{ROW_ITEM, C_REF, 8'h56, 5'd0,  1'b0, '0},
      '{ROW_CSR,  C_REF, 8'h00, 5'd17, 1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h12, 5'd0,  1'b0, '0},
      '{ROW_CSR,  C_REF, 8'h00, 5'd1,  1'b0, '0},
      '{ROW_ITEM, C_RST, 8'h00, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd0}},
      '{ROW_ITEM, C_REF, 8'h80, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 8'h00, 16'd1}},
      '{ROW_ITEM, C_REF, 8'h7f, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 8'h80, 16'd2}},
      '{ROW_CSR,  C_REF, 8'h00, 5'd16, 1'b0, '0},
      '{ROW_ITEM, C_REF, 8'h00, 5'd0,  1'b0, '0}
   };

   localparam logic [4:0] PHASE_CFG [RAND_PHASES] = '{
      5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd3, 5'd16, 5'd0, 5'd0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [lpr_pkg::CFG_W-1:0] csr_write_data = '0;

   lpr_req_if #(.PAGE_BITS(8)) req_bus ();
   lpr_rsp_if #(.IDX_W(4), .PAGE_BITS(8)) rsp_bus ();

   lru_page_replacement #(
      .MAX_FRAMES(NFRAMES),
      .PAGE_BITS(8)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the frame table
   logic [7:0]  shadow_page [NFRAMES];
   logic [3:0]  shadow_rank [NFRAMES];
   logic [4:0]  shadow_filled = '0;
   logic [15:0] shadow_faults = '0;
   logic [4:0]  shadow_limit = lpr_pkg::CFG_RESET;

   lru_result_type pending_lookups [$];
   bit          idle_en = 1'b1;
   int          n_errors = 0;
   int          n_results = 0;
   int          n_items = 0;
   int          n_hits = 0;
   int          n_evicts = 0;
   int          n_restarts = 0;
   int          cycle_count = 0;

   function automatic void move_to_front(input int sel, input int old_rank);
      for (int i = 0; i < shadow_filled && i < NFRAMES; i++)
         if (i != sel && shadow_rank[i] < old_rank)
            shadow_rank[i] = shadow_rank[i] + 4'd1;
      shadow_rank[sel] = 4'd0;
   endfunction

   function automatic lru_result_type lru_lookup(input logic cmd, input logic [7:0] page);
      lru_result_type r;
      int usable;
      int sel;
      int worst;
      bit found;
      r = '0;
      found = 1'b0;
      sel = 0;
      if (cmd == C_RST) begin
         shadow_filled = '0;
         shadow_faults = '0;
         for (int i = 0; i < NFRAMES; i++)
            shadow_rank[i] = 4'd0;
      end else begin
         for (int i = 0; i < shadow_filled && i < NFRAMES && !found; i++)
            if (shadow_page[i] == page) begin
               found = 1'b1;
               sel = i;
            end
         if (found) begin
            r.hit = 1'b1;
            move_to_front(sel, shadow_rank[sel]);
         end else begin
            if (shadow_faults != lpr_pkg::FAULT_MAX)
               shadow_faults = shadow_faults + 16'd1;
            usable = (shadow_limit == 0) ? 1 : (shadow_limit > NFRAMES) ? NFRAMES
                                                                           : shadow_limit;
            if (shadow_filled < usable) begin
               sel = shadow_filled;
               shadow_page[sel] = page;
               shadow_rank[sel] = shadow_filled[3:0];
               shadow_filled = shadow_filled + 5'd1;
               move_to_front(sel, shadow_filled);
            end else begin
               // oldest rank wins, ties go to the highest frame
               worst = 0;
               for (int i = 0; i < shadow_filled && i < NFRAMES; i++)
                  if (shadow_rank[i] >= worst) begin
                     worst = shadow_rank[i];
                     sel = i;
                  end
               r.evicted_valid = 1'b1;
               r.evicted_page = shadow_page[sel];
               shadow_page[sel] = page;
               move_to_front(sel, worst);
            end
         end
         r.frame_index = sel[3:0];
      end
      r.fault_count = shadow_faults;
      return r;
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] page, input logic typed,
                            input lru_result_type want);
      int gap;
      lru_result_type pred;
      gap = idle_en ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.command = cmd;
      req_bus.page_number = page;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pred = lru_lookup(cmd, page);
      pending_lookups.push_back(typed ? want : pred);
      n_items++;
      n_hits += pred.hit;
      n_evicts += pred.evicted_valid;
      if (cmd == C_RST)
         n_restarts++;
   endtask

   task automatic csr_write(input logic [4:0] value);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      shadow_limit = value;
   endtask

   task automatic field_miss(input string fld, input logic [15:0] want_v,
                             input logic [15:0] got_v);
      n_errors++;
      if (n_errors <= 10)
         $display("mismatch in %s on result %0d: expected %0h, got %0h",
                  fld, n_results, want_v, got_v);
   endtask

   // result side: random stalls, then compare against the oldest pending lookup
   initial begin
      int stall_left;
      lru_result_type got;
      lru_result_type want;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
         @(posedge clock);
         if (rsp_bus.ready && rsp_bus.valid === 1'b1) begin
            got = '{rsp_bus.hit, rsp_bus.frame_index, rsp_bus.evicted_valid,
                    rsp_bus.evicted_page, rsp_bus.fault_count};
            n_results++;
            if (pending_lookups.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("result %0d arrived with no lookup pending", n_results);
            end else begin
               want = pending_lookups.pop_front();
               if (got.hit !== want.hit)
                  field_miss("hit", 16'(want.hit), 16'(got.hit));
               if (got.frame_index !== want.frame_index)
                  field_miss("frame_index", 16'(want.frame_index), 16'(got.frame_index));
               if (got.evicted_valid !== want.evicted_valid)
                  field_miss("evicted_valid", 16'(want.evicted_valid),
                             16'(got.evicted_valid));
               if (got.evicted_page !== want.evicted_page)
                  field_miss("evicted_page", 16'(want.evicted_page),
                             16'(got.evicted_page));
               if (got.fault_count !== want.fault_count)
                  field_miss("fault_count", want.fault_count, got.fault_count);
            end
            stall_left = idle_en ? $urandom_range(0, 4) : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int k;
      int ph;
      int j;
      int usable;
      int psize;
      int pick;
      logic [4:0] cfgv;
      logic [7:0] pool [20];
      req_bus.valid = 1'b0;
      req_bus.command = C_REF;
      req_bus.page_number = '0;
      for (k = 0; k < NFRAMES; k++) begin
         shadow_page[k] = '0;
         shadow_rank[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < DIR_N; k++) begin
         if (DIR_ROWS[k].kind == ROW_CSR)
            csr_write(DIR_ROWS[k].csr);
         else
            send_item(DIR_ROWS[k].cmd, DIR_ROWS[k].page, DIR_ROWS[k].typed,
                      DIR_ROWS[k].want);
      end

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         cfgv = (ph >= 10) ? 5'($urandom_range(0, 31)) : PHASE_CFG[ph];
         csr_write(cfgv);
         idle_en = (ph % 4) != 2;
         usable = (cfgv == 0) ? 1 : (cfgv > NFRAMES) ? NFRAMES : cfgv;
         // working set from all-hit to thrashing around the frame count
         psize = $urandom_range(1, usable + 4);
         if (psize > 20)
            psize = 20;
         for (j = 0; j < 20; j++)
            pool[j] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1))
            send_item(C_RST, 8'($urandom_range(0, 255)), 1'b0, '0);
         for (j = 0; j < PHASE_ITEMS; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               send_item(C_RST, 8'($urandom_range(0, 255)), 1'b0, '0);
            else if (pick < 12)
               send_item(C_REF, 8'($urandom_range(0, 255)), 1'b0, '0);
            else
               send_item(C_REF, pool[$urandom_range(0, psize - 1)], 1'b0, '0);
         end
      end

      // one frame and two alternating pages: after the first fill, every reference evicts the other page
      csr_write(5'd1);
      idle_en = 1'b0;
      send_item(C_RST, 8'h00, 1'b0, '0);
      for (j = 0; j < THRASH_REFS; j++)
         send_item(C_REF, j[0] ? 8'h3c : 8'hc3, 1'b0, '0);
      idle_en = 1'b1;
      send_item(C_REF, 8'h3c, 1'b0, '0);
      send_item(C_REF, 8'hc3, 1'b0, '0);
      send_item(C_RST, 8'h00, 1'b0, '0);
      send_item(C_REF, 8'hc3, 1'b0, '0);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d items (%0d restarts), %0d hits, %0d evictions, %0d results checked",
               n_items, n_restarts, n_hits, n_evicts, n_results);
      $display("frame limits from 0 to 31 incl. out-of-range, stalls both sides, %0d errors",
               n_errors);
      if (n_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
